// ===== hw/rtl/tos_pkg.sv =====
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types and constants of the timed output sequencer.
// ----------------------------------------------------------------------------
package tos_pkg;

	localparam int SEC_W  = 20;
	localparam int OUT_W  = 6;
	localparam int OP_W   = 3;
	localparam int CH_W   = 3;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [SEC_W-1:0] SEC_MAX       = {SEC_W{1'b1}};
	localparam logic [SEC_W-1:0] END_RESET     = SEC_W'(120);
	localparam logic [SEC_W-1:0] OFF_SEC_RESET = SEC_W'(10);
	localparam logic [SEC_W-1:0] ON_SEC_RESET  = '0;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_START  = 3'd1,
		OP_PAUSE  = 3'd2,
		OP_RESUME = 3'd3,
		OP_STOP   = 3'd4,
		OP_WRITE  = 3'd5
	} op_t;

	typedef enum logic {
		REG_START_SECOND = 1'b0,
		REG_END_SECOND   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic eval;
		logic clr_all;
		logic clr_fired;
		logic wr;
	} sched_ctrl_t;

endpackage

// ===== hw/rtl/timed_output_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// timed_output_sequencer_core
// Timed switching script over a set of outputs, driven by tick and command
// beats.
// ----------------------------------------------------------------------------
// Each input beat (a tick or a command) gives one result beat. A beat is
// captured in an input register and evaluated combinationally against the
// run state, the run clock and all schedule entries in parallel; the result
// lands in the output register once that register is free. One beat is taken
// every cycle while the output side keeps up; a stalled result holds the
// input register, and only then does in_ready fall. Start and end seconds sit
// in an APB register file at byte addresses 0 and 4 and should be changed
// only while no beat is in flight.
module timed_output_sequencer_core #(
	parameter int CHANNELS         = 6,
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tos_pkg::ADDR_W-1:0] paddr,
	input  logic [tos_pkg::DATA_W-1:0] pwdata,
	output logic [tos_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tos_pkg::OP_W-1:0]   op,
	input  logic                       safety_stop,
	input  logic [tos_pkg::CH_W-1:0]   channel,
	input  logic                       entry_enable,
	input  logic [tos_pkg::SEC_W-1:0]  entry_on_second,
	input  logic [tos_pkg::SEC_W-1:0]  entry_off_second,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tos_pkg::OUT_W-1:0]  output_levels,
	output logic [tos_pkg::OUT_W-1:0]  changed_mask,
	output logic [tos_pkg::SEC_W-1:0]  script_second,
	output logic                       is_running,
	output logic                       is_paused,
	output logic                       finished,
	output logic                       ended_early
);
	import tos_pkg::*;

	localparam int LW = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;

	// input stage
	logic             v_s1;
	op_t              op_s1;
	logic             safety_s1;
	logic [CH_W-1:0]  channel_s1;
	logic             enable_s1;
	logic [SEC_W-1:0] on_s1;
	logic [SEC_W-1:0] off_s1;

	// run state
	logic run_q;
	logic pause_q;
	logic early_q;

	// result stage
	logic             out_v_s2;
	logic [OUT_W-1:0] levels_s2;
	logic [OUT_W-1:0] changed_s2;
	logic [SEC_W-1:0] sec_s2;
	logic             running_s2;
	logic             paused_s2;
	logic             finished_s2;
	logic             early_s2;

	logic [SEC_W-1:0]    start_second;
	logic [SEC_W-1:0]    end_second;
	logic [SEC_W-1:0]    sec_next;
	logic [CHANNELS-1:0] level_q;
	logic [CHANNELS-1:0] level_n;
	logic [LW-1:0]       level_q_ext;
	logic [LW-1:0]       level_n_ext;
	sched_ctrl_t         sctrl;

	logic go;
	logic tick_run;
	logic do_start;
	logic do_pause;
	logic do_resume;
	logic user_stop;
	logic do_write;
	logic done_end;
	logic run_n;
	logic pause_n;
	logic early_n;

	assign go       = v_s1 && (!out_v_s2 || out_ready);
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op_t'(op);
			safety_s1  <= safety_stop;
			channel_s1 <= channel;
			enable_s1  <= entry_enable;
			on_s1      <= entry_on_second;
			off_s1     <= entry_off_second;
		end
	end

	// command decode
	always_comb begin
		tick_run  = 1'b0;
		do_start  = 1'b0;
		do_pause  = 1'b0;
		do_resume = 1'b0;
		user_stop = 1'b0;
		do_write  = 1'b0;
		unique case (op_s1)
			OP_TICK:   tick_run  = go && run_q && !pause_q;
			OP_START:  do_start  = go && !run_q && !safety_s1;
			OP_PAUSE:  do_pause  = go && run_q && !pause_q;
			OP_RESUME: do_resume = go && run_q && pause_q;
			OP_STOP:   user_stop = go && run_q;
			OP_WRITE:  do_write  = go && !run_q;
			default: ;
		endcase
	end

	assign done_end = tick_run && (sec_next >= end_second);

	assign sctrl.eval      = tick_run && !done_end;
	assign sctrl.clr_all   = do_start;
	assign sctrl.clr_fired = done_end || user_stop;
	assign sctrl.wr        = do_write;

	always_comb begin
		run_n   = run_q;
		pause_n = pause_q;
		early_n = early_q;
		if (do_start) begin
			run_n   = 1'b1;
			pause_n = 1'b0;
			early_n = 1'b0;
		end else if (done_end || user_stop) begin
			run_n   = 1'b0;
			pause_n = 1'b0;
			early_n = user_stop;
		end else if (do_pause) begin
			pause_n = 1'b1;
		end else if (do_resume) begin
			pause_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			pause_q <= 1'b0;
			early_q <= 1'b0;
		end else begin
			run_q   <= run_n;
			pause_q <= pause_n;
			early_q <= early_n;
		end
	end

	tos_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start_second (start_second),
		.end_second   (end_second)
	);

	tos_run_clock #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_clock (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (do_start),
		.advance      (tick_run),
		.start_second (start_second),
		.sec_next     (sec_next)
	);

	tos_sched #(
		.CHANNELS (CHANNELS)
	) u_sched (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (sctrl),
		.sec           (sec_next),
		.wr_chan       (channel_s1),
		.wr_enable     (enable_s1),
		.wr_on_second  (on_s1),
		.wr_off_second (off_s1),
		.level_q       (level_q),
		.level_n       (level_n)
	);

	assign level_q_ext = LW'(level_q);
	assign level_n_ext = LW'(level_n);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s2 <= 1'b0;
		end else if (go) begin
			out_v_s2 <= 1'b1;
		end else if (out_ready) begin
			out_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			levels_s2   <= level_n_ext[OUT_W-1:0];
			changed_s2  <= level_q_ext[OUT_W-1:0] ^ level_n_ext[OUT_W-1:0];
			sec_s2      <= sec_next;
			running_s2  <= run_n;
			paused_s2   <= pause_n;
			finished_s2 <= done_end || user_stop;
			early_s2    <= early_n;
		end
	end

	assign out_valid     = out_v_s2;
	assign output_levels = levels_s2;
	assign changed_mask  = changed_s2;
	assign script_second = sec_s2;
	assign is_running    = running_s2;
	assign is_paused     = paused_s2;
	assign finished      = finished_s2;
	assign ended_early   = early_s2;

endmodule

// ===== hw/rtl/tos_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tos_cfg_regs
// APB-style register file holding the start and end seconds of the script.
// ----------------------------------------------------------------------------
module tos_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tos_pkg::ADDR_W-1:0] paddr,
	input  logic [tos_pkg::DATA_W-1:0] pwdata,
	output logic [tos_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [tos_pkg::SEC_W-1:0]  start_second,
	output logic [tos_pkg::SEC_W-1:0]  end_second
);
	import tos_pkg::*;

	logic [SEC_W-1:0] start_q;
	logic [SEC_W-1:0] end_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign idx   = reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= END_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_SECOND: start_q <= pwdata[SEC_W-1:0];
				REG_END_SECOND:   end_q   <= pwdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_SECOND: prdata = DATA_W'(start_q);
			REG_END_SECOND:   prdata = DATA_W'(end_q);
			default:          prdata = '0;
		endcase
	end

	assign start_second = start_q;
	assign end_second   = end_q;

endmodule

// ===== hw/rtl/tos_run_clock.sv =====
// ----------------------------------------------------------------------------
// tos_run_clock
// Run clock (ticks within the second and whole seconds) and the rounded
// script second derived from it.
// ----------------------------------------------------------------------------
module tos_run_clock #(
	parameter int TICKS_PER_SECOND = 1000
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      advance,
	input  logic [tos_pkg::SEC_W-1:0] start_second,
	output logic [tos_pkg::SEC_W-1:0] sec_next
);
	import tos_pkg::*;

	localparam int MW = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [MW-1:0] LAST_TICK = MW'(TICKS_PER_SECOND - 1);
	localparam logic [MW-1:0] HALF_TICK = MW'(TICKS_PER_SECOND - TICKS_PER_SECOND / 2);

	logic [MW-1:0]    ticks_q;
	logic [MW-1:0]    ticks_n;
	logic [SEC_W-1:0] elapsed_q;
	logic [SEC_W-1:0] elapsed_n;
	logic [SEC_W:0]   sum;

	always_comb begin
		ticks_n   = ticks_q;
		elapsed_n = elapsed_q;
		if (clear) begin
			ticks_n   = '0;
			elapsed_n = '0;
		end else if (advance) begin
			if (ticks_q >= LAST_TICK) begin
				// clock holds once the second count is full
				if (elapsed_q != SEC_MAX) begin
					elapsed_n = elapsed_q + SEC_W'(1);
					ticks_n   = '0;
				end
			end else begin
				ticks_n = ticks_q + MW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= '0;
			elapsed_q <= '0;
		end else begin
			ticks_q   <= ticks_n;
			elapsed_q <= elapsed_n;
		end
	end

	// round to nearest second, then saturate
	assign sum = {1'b0, start_second} + {1'b0, elapsed_n}
		+ (SEC_W+1)'(ticks_n >= HALF_TICK);
	assign sec_next = sum[SEC_W] ? SEC_MAX : sum[SEC_W-1:0];

endmodule

// ===== hw/rtl/tos_sched.sv =====
// ----------------------------------------------------------------------------
// tos_sched
// Schedule table and per-channel switching, all channels checked side by side.
// ----------------------------------------------------------------------------
module tos_sched #(
	parameter int CHANNELS = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tos_pkg::sched_ctrl_t      ctrl,
	input  logic [tos_pkg::SEC_W-1:0] sec,
	input  logic [tos_pkg::CH_W-1:0]  wr_chan,
	input  logic                      wr_enable,
	input  logic [tos_pkg::SEC_W-1:0] wr_on_second,
	input  logic [tos_pkg::SEC_W-1:0] wr_off_second,
	output logic [CHANNELS-1:0]       level_q,
	output logic [CHANNELS-1:0]       level_n
);
	import tos_pkg::*;

	logic [CHANNELS-1:0] enable_q;
	logic [SEC_W-1:0]    on_sec_q  [CHANNELS];
	logic [SEC_W-1:0]    off_sec_q [CHANNELS];
	logic [CHANNELS-1:0] on_fired_q;
	logic [CHANNELS-1:0] off_fired_q;
	logic [CHANNELS-1:0] on_fired_n;
	logic [CHANNELS-1:0] off_fired_n;
	logic [CHANNELS-1:0] on_hit;
	logic [CHANNELS-1:0] off_hit;
	logic [CHANNELS-1:0] level_mid;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			on_hit[i]    = enable_q[i] && (sec >= on_sec_q[i]) && !on_fired_q[i]
				&& !level_q[i];
			level_mid[i] = level_q[i] | on_hit[i];
			// off can follow on within the same tick
			off_hit[i]   = enable_q[i] && (sec >= off_sec_q[i]) && !off_fired_q[i]
				&& level_mid[i];
		end

		level_n     = level_q;
		on_fired_n  = on_fired_q;
		off_fired_n = off_fired_q;
		if (ctrl.clr_all) begin
			level_n     = '0;
			on_fired_n  = '0;
			off_fired_n = '0;
		end else if (ctrl.clr_fired) begin
			on_fired_n  = '0;
			off_fired_n = '0;
		end else if (ctrl.eval) begin
			level_n     = level_mid & ~off_hit;
			on_fired_n  = on_fired_q | on_hit;
			off_fired_n = off_fired_q | off_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			on_fired_q  <= '0;
			off_fired_q <= '0;
			enable_q    <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				on_sec_q[i]  <= ON_SEC_RESET;
				off_sec_q[i] <= OFF_SEC_RESET;
			end
		end else begin
			level_q     <= level_n;
			on_fired_q  <= on_fired_n;
			off_fired_q <= off_fired_n;
			for (int i = 0; i < CHANNELS; i++) begin
				if (ctrl.wr && (32'(wr_chan) == i)) begin
					enable_q[i]  <= wr_enable;
					on_sec_q[i]  <= wr_on_second;
					off_sec_q[i] <= wr_off_second;
				end
			end
		end
	end

endmodule
